>>> design/two_class_fifo_oldest_first_defines.svh
// Assertion macros for the two-class FIFO block.
// Used by the top level only; relies on signals named clock and reset in scope.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCFO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/tcfo_pkg.sv
// Shared types and constants for the two-class FIFO block.
// No dependencies; every other file of the block but the defines header uses this package.
`timescale 1ns / 1ps

package tcfo_pkg;

   localparam int unsigned HANDLE_WIDTH  = 16;
   localparam int unsigned SEQ_WIDTH     = 16;
   localparam int unsigned DEPTH_DEFAULT = 16;

   // Command queue between the front and the back.
   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Request action codes.
   localparam logic [1:0] ACT_ENQ     = 2'd0;
   localparam logic [1:0] ACT_DEQ_ANY = 2'd1;
   localparam logic [1:0] ACT_DEQ_CLS = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_ENQ   = 2'd0;
   localparam logic [1:0] ST_DEQ   = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]              action;
      logic                    item_class;
      logic [HANDLE_WIDTH-1:0] handle;
   } req_word_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    out_class;
      logic [HANDLE_WIDTH-1:0] out_handle;
      logic [SEQ_WIDTH-1:0]    arrival_seq;
   } rsp_word_type;

   typedef enum logic [1:0] {
      K_ENQ     = 2'd0,
      K_DEQ_ANY = 2'd1,
      K_DEQ_CLS = 2'd2,
      K_BAD     = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    cls;
      logic [HANDLE_WIDTH-1:0] handle;
   } cmd_type;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] handle;
      logic [SEQ_WIDTH-1:0]    seq;
   } entry_type;

endpackage

>>> design/tcfo_front.sv
// Front stage: accepts request words and decodes them into commands.
// Depends on tcfo_pkg; feeds tcfo_cmdq.
`timescale 1ns / 1ps

module tcfo_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcfo_pkg::req_word_type req_word,
   output logic                   push_valid,
   input  logic                   push_ready,
   output tcfo_pkg::cmd_type      push_cmd
);

   logic              front_valid_ff;
   logic              front_valid_in;
   tcfo_pkg::cmd_type front_cmd_ff;
   tcfo_pkg::cmd_type front_cmd_in;
   tcfo_pkg::cmd_type decoded;

   always_comb begin
      decoded.cls    = req_word.item_class;
      decoded.handle = req_word.handle;
      unique case (req_word.action)
         tcfo_pkg::ACT_ENQ:     decoded.kind = tcfo_pkg::K_ENQ;
         tcfo_pkg::ACT_DEQ_ANY: decoded.kind = tcfo_pkg::K_DEQ_ANY;
         tcfo_pkg::ACT_DEQ_CLS: decoded.kind = tcfo_pkg::K_DEQ_CLS;
         default:               decoded.kind = tcfo_pkg::K_BAD;
      endcase
   end

   // The stage refills whenever it is empty or its command moves on.
   assign req_stall = front_valid_ff && !push_ready;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_cmd_in   = front_cmd_ff;
      if (!req_stall) begin
         front_valid_in = req_valid;
         if (req_valid) begin
            front_cmd_in = decoded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_cmd_ff <= front_cmd_in;
   end

   assign push_valid = front_valid_ff;
   assign push_cmd   = front_cmd_ff;

endmodule

>>> design/tcfo_cmdq.sv
// Short command queue between the front and the back stage.
// Depends on tcfo_pkg for the command type and queue depth.
`timescale 1ns / 1ps

module tcfo_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tcfo_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_en,
   output tcfo_pkg::cmd_type pop_cmd
);

   localparam int unsigned PTR_W = tcfo_pkg::CMDQ_PTR_W;
   localparam int unsigned CNT_W = tcfo_pkg::CMDQ_CNT_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tcfo_pkg::CMDQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tcfo_pkg::CMDQ_DEPTH);

   tcfo_pkg::cmd_type slot_ff [tcfo_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              push_fire;

   assign push_ready = fill_ff != CNT_FULL;
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push_fire, pop_en})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/tcfo_back.sv
// Back stage: holds both class stores, executes commands, drives responses.
// Depends on tcfo_pkg; takes commands from tcfo_cmdq.
`timescale 1ns / 1ps

module tcfo_back #(
   parameter int unsigned DEPTH = tcfo_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  tcfo_pkg::cmd_type      cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcfo_pkg::rsp_word_type rsp_word
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SEQ_W = tcfo_pkg::SEQ_WIDTH;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   tcfo_pkg::entry_type first_mem  [DEPTH];
   tcfo_pkg::entry_type second_mem [DEPTH];
   tcfo_pkg::entry_type head_rd_ff [2];

   logic [PTR_W-1:0] head_ff  [2];
   logic [PTR_W-1:0] head_in  [2];
   logic [PTR_W-1:0] tail_ff  [2];
   logic [PTR_W-1:0] tail_in  [2];
   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;

   tcfo_pkg::cmd_type      cmd_ff, cmd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tcfo_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                   exec;
   logic                   empty0, empty1, sel_full, sel_empty;
   logic [SEQ_W-1:0]       seq_diff;
   logic                   any_pick1;
   logic                   do_pop, do_enq, pop_cls;
   tcfo_pkg::rsp_word_type result;

   assign exec    = state_ff == S_EXEC;
   // A result register that is empty or being emptied can take the next result.
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      empty0    = count_ff[0] == '0;
      empty1    = count_ff[1] == '0;
      sel_full  = count_ff[cmd_ff.cls] == CNT_FULL;
      sel_empty = count_ff[cmd_ff.cls] == '0;
      seq_diff  = head_rd_ff[0].seq - head_rd_ff[1].seq;
      // Class 1 wins when class 0 is empty, or when class 0's head is strictly newer by less than half the range.
      any_pick1 = empty0 || (!empty1 && (seq_diff != '0) && !seq_diff[SEQ_W-1]);
      do_pop    = 1'b0;
      do_enq    = 1'b0;
      pop_cls   = 1'b0;
      result    = '0;
      result.out_class = cmd_ff.cls;
      unique case (cmd_ff.kind)
         tcfo_pkg::K_ENQ: begin
            if (sel_full) begin
               result.status = tcfo_pkg::ST_FULL;
            end else begin
               do_enq             = 1'b1;
               result.status      = tcfo_pkg::ST_ENQ;
               result.arrival_seq = next_seq_ff;
            end
         end
         tcfo_pkg::K_DEQ_ANY: begin
            if (empty0 && empty1) begin
               result.status    = tcfo_pkg::ST_EMPTY;
               result.out_class = 1'b0;
            end else begin
               do_pop  = 1'b1;
               pop_cls = any_pick1;
            end
         end
         tcfo_pkg::K_DEQ_CLS: begin
            if (sel_empty) begin
               result.status = tcfo_pkg::ST_EMPTY;
            end else begin
               do_pop  = 1'b1;
               pop_cls = cmd_ff.cls;
            end
         end
         default: begin
            result.status = tcfo_pkg::ST_EMPTY;
         end
      endcase
      if (do_pop) begin
         result.status      = tcfo_pkg::ST_DEQ;
         result.out_class   = pop_cls;
         result.out_handle  = head_rd_ff[pop_cls].handle;
         result.arrival_seq = head_rd_ff[pop_cls].seq;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      next_seq_in  = next_seq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      for (int c = 0; c < 2; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
      end
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_word_in  = result;
            if (do_enq) begin
               tail_in[cmd_ff.cls]  = (tail_ff[cmd_ff.cls] == PTR_LAST) ? '0
                                    : tail_ff[cmd_ff.cls] + PTR_W'(1);
               count_in[cmd_ff.cls] = count_ff[cmd_ff.cls] + CNT_W'(1);
               next_seq_in          = next_seq_ff + SEQ_W'(1);
            end
            if (do_pop) begin
               head_in[pop_cls]  = (head_ff[pop_cls] == PTR_LAST) ? '0
                                 : head_ff[pop_cls] + PTR_W'(1);
               count_in[pop_cls] = count_ff[pop_cls] - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 2; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < 2; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
      end
      cmd_ff      <= cmd_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Store memories: one write port at the tail, one registered read port at the head.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         head_rd_ff[0] <= first_mem[head_ff[0]];
         head_rd_ff[1] <= second_mem[head_ff[1]];
      end
      if (exec && do_enq && !cmd_ff.cls) begin
         first_mem[tail_ff[0]] <= '{handle: cmd_ff.handle, seq: next_seq_ff};
      end
      if (exec && do_enq && cmd_ff.cls) begin
         second_mem[tail_ff[1]] <= '{handle: cmd_ff.handle, seq: next_seq_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> design/two_class_fifo_oldest_first.sv
// Top level of the two-class FIFO with oldest-first dequeue.
// Depends on tcfo_pkg, tcfo_front, tcfo_cmdq, tcfo_back and the defines header.
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_defines.svh"

// Usage:
// The request channel (req_valid, req_stall, req_word) takes one word per command:
// enqueue a handle into class 0 or 1, dequeue the oldest item of either class, or
// dequeue the head of a named class. Every request word produces exactly one
// response word on the response channel (rsp_valid, rsp_stall, rsp_word) with a
// status of enqueued, dequeued, empty or full, in request order.
// Each class keeps a FIFO of DEPTH entries holding the handle and a shared arrival
// sequence number; dequeue-any compares the two heads' numbers modulo 2^16.
// A request passes through the front register, the command queue, the back's
// command register and the response register. The back stage takes no new command
// until the last has executed: it first reads both heads through the stores'
// registered read port and then executes the command in the following cycle.
// A front register and a two-entry command queue keep accepting requests while a
// finished response waits on rsp_stall; requests stall once both are full.
// A synchronous reset empties both FIFOs, the command queue and the response
// register and restarts the sequence counter at zero. Store contents are not
// cleared, since an entry is read only after it has been written.
module two_class_fifo_oldest_first #(
   parameter int unsigned DEPTH = tcfo_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcfo_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcfo_pkg::rsp_word_type rsp_word
);

   // Front to queue.
   logic              front_valid;
   logic              push_ready;
   tcfo_pkg::cmd_type front_cmd;

   // Queue to back.
   logic              cmd_valid;
   logic              cmd_pop;
   tcfo_pkg::cmd_type queued_cmd;

   // The front decodes each request word into a command and holds it until the
   // queue has room.
   tcfo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .push_valid (front_valid),
      .push_ready (push_ready),
      .push_cmd   (front_cmd)
   );

   // The queue decouples the front from the back so either can stall alone.
   tcfo_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (push_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (cmd_valid),
      .pop_en     (cmd_pop),
      .pop_cmd    (queued_cmd)
   );

   // The back owns both stores, pointers, counts and the sequence counter, and
   // takes a command only when its response register will be free.
   tcfo_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (queued_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // An accepted request must be held in the front stage on the next cycle.
   `TCFO_ASSERT_NEXT(a_req_lands_in_front, req_valid && !req_stall, front_valid, "request lost")
   // The back must never pop an empty command queue.
   `TCFO_ASSERT_NOW(a_pop_nonempty, cmd_pop, cmd_valid, "back popped an empty command queue")
   // Each command spends its execute cycle in the back before the next is taken.
   `TCFO_ASSERT_NEXT(a_pop_spacing, cmd_pop, !cmd_pop, "back took commands on adjacent cycles")

endmodule
